### src/aes_block_encrypt_decrypt_assert.svh
// Assertion macros for the AES block cipher
`ifndef AES_BLOCK_ENCRYPT_DECRYPT_ASSERT_SVH
`define AES_BLOCK_ENCRYPT_DECRYPT_ASSERT_SVH
`ifndef SYNTHESIS
`define AES_ASSERT_IMP(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed");
`define AES_ASSERT_NEXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("assertion failed");
`else
`define AES_ASSERT_IMP(label, clk, rst, a, c)
`define AES_ASSERT_NEXT(label, clk, rst, a, c)
`endif
`endif

### src/aes_pkg.sv
// Shared constants, tables and functions of the AES block cipher
package aes_pkg;
  localparam int KeyStoreDepth = 60;
  localparam int KsIdxW = 6;
  localparam logic [1:0] KsAddr = 2'd0;
  localparam logic FuncEnc = 1'b0;
  localparam logic FuncDec = 1'b1;

  function automatic logic [7:0] sbox(input logic [7:0] a);
    logic [7:0] t [256];
    t = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
    return t[a];
  endfunction

  function automatic logic [7:0] inv_sbox(input logic [7:0] a);
    logic [7:0] t [256];
    t = '{
      8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
      8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
      8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
      8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
      8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
      8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
      8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
      8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
      8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
      8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
      8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
      8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
      8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
      8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
      8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
      8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};
    return t[a];
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
  endfunction

  function automatic logic [31:0] mix_col(input logic [31:0] c);
    logic [7:0] a0, a1, a2, a3;
    a0 = c[31:24]; a1 = c[23:16]; a2 = c[15:8]; a3 = c[7:0];
    return {xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3,
            a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3,
            a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3,
            xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3)};
  endfunction

  function automatic logic [31:0] inv_mix_col(input logic [31:0] c);
    logic [7:0] a [4];
    logic [7:0] x2 [4];
    logic [7:0] x4 [4];
    logic [7:0] x8 [4];
    logic [7:0] m9 [4];
    logic [7:0] mb [4];
    logic [7:0] md [4];
    logic [7:0] me [4];
    a[0] = c[31:24]; a[1] = c[23:16]; a[2] = c[15:8]; a[3] = c[7:0];
    for (int k = 0; k < 4; k++) begin
      x2[k] = xtime(a[k]);
      x4[k] = xtime(x2[k]);
      x8[k] = xtime(x4[k]);
      m9[k] = x8[k] ^ a[k];
      mb[k] = x8[k] ^ x2[k] ^ a[k];
      md[k] = x8[k] ^ x4[k] ^ a[k];
      me[k] = x8[k] ^ x4[k] ^ x2[k];
    end
    return {me[0] ^ mb[1] ^ md[2] ^ m9[3],
            m9[0] ^ me[1] ^ mb[2] ^ md[3],
            md[0] ^ m9[1] ^ me[2] ^ mb[3],
            mb[0] ^ md[1] ^ m9[2] ^ me[3]};
  endfunction

  function automatic logic [127:0] shift_rows(input logic [127:0] s, input logic inv);
    logic [127:0] t;
    int src;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        src = inv ? ((c + 4 - r) % 4) : ((c + r) % 4);
        t[127 - 8 * (4 * c + r) -: 8] = s[127 - 8 * (4 * src + r) -: 8];
      end
    end
    return t;
  endfunction
endpackage

### src/aes_key_exp.sv
// Key expansion sequencer writing one round-key word per cycle
module aes_key_exp
  import aes_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [1:0]        key_size,
  input  logic [255:0]      key,
  output logic              busy,
  output logic              wr_en,
  output logic [KsIdxW-1:0] wr_addr,
  output logic [31:0]       wr_data
);
  logic [KsIdxW-1:0] idx;
  logic [2:0] pos;
  logic [2:0] nk;
  logic [KsIdxW-1:0] total;
  logic [7:0] rcon;
  logic [31:0] win [8];
  logic [31:0] t, nw;

  always_comb begin
    unique case (key_size)
      2'd0: begin nk = 3'd4; total = KsIdxW'(44); end
      2'd1: begin nk = 3'd6; total = KsIdxW'(52); end
      default: begin nk = 3'd0; total = KsIdxW'(KeyStoreDepth); end
    endcase
  end

  always_comb begin
    t = win[0];
    if (pos == 3'd0) t = sub_word({win[0][23:0], win[0][31:24]}) ^ {rcon, 24'h0};
    else if (nk == 3'd0 && pos == 3'd4) t = sub_word(win[0]);
    nw = (nk == 3'd4 ? win[3] : (nk == 3'd6 ? win[5] : win[7])) ^ t;
  end

  assign wr_en = busy;
  assign wr_addr = idx;
  assign wr_data = idx < KsIdxW'(nk == 3'd0 ? 8 : nk) ? key[255 - 32 * idx[2:0] -: 32] : nw;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
      idx <= '0;
      pos <= 3'd0;
      rcon <= 8'h01;
    end else if (busy) begin
      for (int k = 7; k > 0; k--) win[k] <= win[k - 1];
      win[0] <= wr_data;
      if (idx >= KsIdxW'(nk == 3'd0 ? 8 : nk)) begin
        if (pos == (nk == 3'd0 ? 3'd7 : nk - 3'd1)) pos <= 3'd0;
        else pos <= pos + 3'd1;
        if (idx >= KsIdxW'(nk == 3'd0 ? 8 : nk) && pos == 3'd0) rcon <= xtime(rcon);
      end
      if (idx == total - 1'b1) busy <= 1'b0;
      idx <= idx + 1'b1;
    end
  end
endmodule

### src/aes_round.sv
// Round datapath: one combinational cipher round on the 128-bit state
module aes_round
  import aes_pkg::*;
(
  input  logic [127:0] state,
  input  logic [127:0] rk,
  input  logic         dec,
  input  logic         first,
  input  logic         last,
  output logic [127:0] next
);
  logic [127:0] sr, sb, ak, mc;
  always_comb begin
    sr = shift_rows(state, dec);
    for (int i = 0; i < 16; i++)
      sb[8 * i +: 8] = dec ? inv_sbox(sr[8 * i +: 8]) : sbox(sr[8 * i +: 8]);
    ak = sb ^ rk;
    for (int c = 0; c < 4; c++) begin
      mc[32 * c +: 32] = dec ? inv_mix_col(ak[32 * c +: 32]) : mix_col(sb[32 * c +: 32]);
    end
    if (first) next = state ^ rk;
    else if (last) next = ak;
    else if (dec) next = mc;
    else next = mc ^ rk;
  end
endmodule

### src/aes_block_encrypt_decrypt.sv
// Top level of the AES block cipher with APB key setup and stream data
// Channel | dir | handshake          | payload
// s       | in  | s_tvalid/s_tready  | s_tuser=func, s_tdata={block_lo,block_hi}
// m       | out | m_tvalid/m_tready  | m_tdata={result_lo,result_hi}
// cfg     | in  | psel/penable/pready| pwdata 64 bit, paddr 8*index
// Each of the Nr+1 rounds of a block takes one read-latency step,
// four round-key word captures and one pass through the shared round unit.
// After a key or key-size write, the first block waits for key expansion.
// Reset is synchronous; the round-key store is not cleared.
// The input is not ready while a block is in flight or its result waits.
`include "aes_block_encrypt_decrypt_assert.svh"
module aes_block_encrypt_decrypt
  import aes_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [5:0]   paddr,
  input  logic [63:0]  pwdata,
  output logic [63:0]  prdata,
  output logic         pready,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [127:0] s_tdata,  // block_lo, block_hi
  input  logic         s_tuser,  // func
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [127:0] m_tdata   // result_lo, result_hi
);
  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StExp = 2'd1;
  localparam logic [1:0] StRun = 2'd2;
  localparam logic [1:0] StOut = 2'd3;

  logic [1:0] st;
  logic [1:0] key_size;
  logic [63:0] key_word [4];
  logic keys_ready, ks_busy, ks_we, ks_start, dec;
  logic [KsIdxW-1:0] ks_addr;
  logic [31:0] ks_data;
  logic [31:0] store [KeyStoreDepth];
  logic [3:0] round, nr;
  logic [1:0] col;
  logic [127:0] rk, state, next, blk;
  logic wr;

  assign pready = 1'b1;
  assign wr = psel & penable & pwrite;
  always_comb begin
    unique case (paddr[5:3])
      3'd0: prdata = {62'd0, key_size};
      3'd1: prdata = key_word[0];
      3'd2: prdata = key_word[1];
      3'd3: prdata = key_word[2];
      3'd4: prdata = key_word[3];
      default: prdata = '0;
    endcase
  end

  always_comb begin
    unique case (key_size)
      2'd0: nr = 4'd10;
      2'd1: nr = 4'd12;
      default: nr = 4'd14;
    endcase
  end

  assign ks_start = st == StIdle && s_tvalid && !keys_ready;
  aes_key_exp u_kexp (
    .clk(clk), .rst(rst), .start(ks_start), .key_size(key_size),
    .key({key_word[0], key_word[1], key_word[2], key_word[3]}),
    .busy(ks_busy), .wr_en(ks_we), .wr_addr(ks_addr), .wr_data(ks_data)
  );

  // round key is gathered from 4 words; fetched one word per cycle ahead
  logic [3:0] krd;
  logic [31:0] rdw;
  logic [KsIdxW-1:0] raddr;
  assign raddr = KsIdxW'({krd, col});
  always_ff @(posedge clk) begin
    if (ks_we) store[ks_addr] <= ks_data;
    rdw <= store[raddr];
  end

  aes_round u_round (
    .state(state), .rk(rk), .dec(dec), .first(round == 4'd0),
    .last(round == nr), .next(next)
  );

  assign s_tready = st == StIdle && keys_ready;
  assign m_tvalid = st == StOut;
  assign m_tdata = {state[63:0], state[127:64]};
  assign blk = {s_tdata[63:0], s_tdata[127:64]};

  // StRun: 6 sub-steps per round (read latency, 4 word captures, 1 apply)
  logic [2:0] sub;
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= StIdle;
      keys_ready <= 1'b0;
      key_size <= 2'd0;
      for (int k = 0; k < 4; k++) key_word[k] <= '0;
    end else begin
      if (wr) begin
        unique case (paddr[5:3])
          3'd0: begin key_size <= pwdata[1:0]; keys_ready <= 1'b0; end
          3'd1: begin key_word[0] <= pwdata; keys_ready <= 1'b0; end
          3'd2: begin key_word[1] <= pwdata; keys_ready <= 1'b0; end
          3'd3: begin key_word[2] <= pwdata; keys_ready <= 1'b0; end
          3'd4: begin key_word[3] <= pwdata; keys_ready <= 1'b0; end
          default: ;
        endcase
      end
      unique case (st)
        StIdle: begin
          if (ks_start) st <= StExp;
          else if (s_tvalid && s_tready) begin
            st <= StRun;
            state <= blk;
            dec <= s_tuser;
            round <= 4'd0;
            krd <= s_tuser == FuncDec ? nr : 4'd0;
            col <= 2'd0;
            sub <= 3'd0;
          end
        end
        StExp: if (!ks_busy && !ks_start) begin
          st <= StIdle;
          keys_ready <= 1'b1;
        end
        StRun: begin
          sub <= sub + 3'd1;
          col <= col + 2'd1;
          if (sub >= 3'd1 && sub <= 3'd4) rk[127 - 32 * (sub - 3'd1) -: 32] <= rdw;
          if (sub == 3'd5) begin
            sub <= 3'd0;
            col <= 2'd0;
            state <= next;
            krd <= dec ? krd - 4'd1 : krd + 4'd1;
            round <= round + 4'd1;
            if (round == nr) st <= StOut;
          end
        end
        StOut: if (m_tready) st <= StIdle;
        default: st <= StIdle;
      endcase
    end
  end

  `AES_ASSERT_IMP(a_out_ready, clk, rst, m_tvalid, !s_tready)
  `AES_ASSERT_IMP(a_exp_blocks, clk, rst, ks_busy, !s_tready)
  `AES_ASSERT_NEXT(a_take, clk, rst, s_tvalid && s_tready, st == StRun)
endmodule

### sim/aes_tb_pkg.sv
// Register indexes of the cipher's configuration port, shared by the bench files
`timescale 1ns / 1ps
package aes_tb_pkg;
  localparam int RegKeySize = 0;
  localparam int RegKeyWord0 = 1;
  localparam int RegKeyWord1 = 2;
  localparam int RegKeyWord2 = 3;
  localparam int RegKeyWord3 = 4;
endpackage

### sim/aes_block_checker.sv
// Checker: tracks key setup, predicts each cipher block and compares results
`timescale 1ns / 1ps
module aes_block_checker
  import aes_pkg::*;
  import aes_tb_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic         pready,
  input  logic [5:0]   paddr,
  input  logic [63:0]  pwdata,
  input  logic         s_tvalid,
  input  logic         s_tready,
  input  logic [127:0] s_tdata,
  input  logic         s_tuser,
  input  logic         m_tvalid,
  input  logic         m_tready,
  input  logic [127:0] m_tdata,
  output int           errors,
  output int           outstanding
);
  bit [7:0] fwd_tab [256];
  bit [7:0] rev_tab [256];
  bit [31:0] round_keys [60];
  bit [1:0] key_len;
  bit [63:0] key_words [4];
  bit keys_valid;
  bit [127:0] pending_blocks [$];

  function automatic bit [7:0] gf_dbl(bit [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic bit [7:0] gf_mul(bit [7:0] a, bit [7:0] b);
    bit [7:0] acc;
    acc = 0;
    while (b != 0) begin
      if (b[0]) acc ^= a;
      a = gf_dbl(a);
      b = b >> 1;
    end
    return acc;
  endfunction

  function automatic bit [7:0] rotl(bit [7:0] x, int n);
    return (x << n) | (x >> (8 - n));
  endfunction

  function automatic int round_count();
    return key_len >= 2 ? 14 : (key_len == 1 ? 12 : 10);
  endfunction

  function automatic bit [31:0] sub_bytes_word(bit [31:0] w);
    return {fwd_tab[w[31:24]], fwd_tab[w[23:16]], fwd_tab[w[15:8]], fwd_tab[w[7:0]]};
  endfunction

  function automatic void expand_key();
    int nr, nk, total;
    bit [31:0] t;
    bit [7:0] rc;
    nr = round_count();
    nk = nr - 6;
    total = 4 * (nr + 1);
    rc = 8'h01;
    for (int i = 0; i < nk; i++)
      round_keys[i] = i[0] ? key_words[i >> 1][31:0] : key_words[i >> 1][63:32];
    for (int i = nk; i < total; i++) begin
      t = round_keys[i - 1];
      if (i % nk == 0) begin
        t = sub_bytes_word({t[23:0], t[31:24]}) ^ {rc, 24'h0};
        rc = gf_dbl(rc);
      end else if (nk > 6 && i % nk == 4) begin
        t = sub_bytes_word(t);
      end
      round_keys[i] = round_keys[i - nk] ^ t;
    end
    keys_valid = 1;
  endfunction

  // byte n of the state sits at [127-8n -: 8]; column c is bytes 4c..4c+3
  function automatic bit [127:0] add_rk(bit [127:0] st, int rd);
    for (int c = 0; c < 4; c++)
      st[127 - 32 * c -: 32] ^= round_keys[4 * rd + c];
    return st;
  endfunction

  function automatic bit [127:0] sub_state(bit [127:0] st, bit inv);
    for (int n = 0; n < 16; n++)
      st[127 - 8 * n -: 8] = inv ? rev_tab[st[127 - 8 * n -: 8]] : fwd_tab[st[127 - 8 * n -: 8]];
    return st;
  endfunction

  function automatic bit [127:0] shift_state(bit [127:0] st, bit inv);
    bit [127:0] t;
    int src;
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++) begin
        src = inv ? ((c + 4 - r) % 4) : ((c + r) % 4);
        t[127 - 8 * (4 * c + r) -: 8] = st[127 - 8 * (4 * src + r) -: 8];
      end
    return t;
  endfunction

  function automatic bit [127:0] mix_state(bit [127:0] st, bit inv);
    bit [7:0] coef [4];
    bit [7:0] col [4];
    bit [7:0] acc;
    if (inv) coef = '{8'h0e, 8'h09, 8'h0d, 8'h0b};
    else coef = '{8'h02, 8'h01, 8'h01, 8'h03};
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) col[r] = st[127 - 8 * (4 * c + r) -: 8];
      for (int r = 0; r < 4; r++) begin
        acc = 0;
        for (int k = 0; k < 4; k++) acc ^= gf_mul(col[k], coef[(r + 4 - k) % 4]);
        st[127 - 8 * (4 * c + r) -: 8] = acc;
      end
    end
    return st;
  endfunction

  function automatic bit [127:0] cipher_block(bit dec, bit [127:0] st);
    int nr;
    if (!keys_valid) expand_key();
    nr = round_count();
    if (dec == FuncEnc) begin
      st = add_rk(st, 0);
      for (int rd = 1; rd < nr; rd++)
        st = add_rk(mix_state(shift_state(sub_state(st, 0), 0), 0), rd);
      st = add_rk(shift_state(sub_state(st, 0), 0), nr);
    end else begin
      st = add_rk(st, nr);
      for (int rd = nr - 1; rd >= 1; rd--)
        st = mix_state(add_rk(sub_state(shift_state(st, 1), 1), rd), 1);
      st = add_rk(sub_state(shift_state(st, 1), 1), 0);
    end
    return st;
  endfunction

  initial begin
    bit [7:0] inv, b;
    for (int a = 0; a < 256; a++) begin
      inv = 0;
      for (int x = 1; x < 256; x++)
        if (a != 0 && gf_mul(a[7:0], x[7:0]) == 8'h01) inv = x[7:0];
      b = inv ^ rotl(inv, 1) ^ rotl(inv, 2) ^ rotl(inv, 3) ^ rotl(inv, 4) ^ 8'h63;
      fwd_tab[a] = b;
      rev_tab[b] = a[7:0];
    end
  end

  always @(posedge clk) begin
    bit [127:0] want;
    if (rst) begin
      keys_valid = 0;
      key_len = 0;
      key_words = '{default: 0};
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (int'(paddr >> 3))
          RegKeySize: begin key_len = pwdata[1:0]; keys_valid = 0; end
          RegKeyWord0, RegKeyWord1, RegKeyWord2, RegKeyWord3: begin
            key_words[int'(paddr >> 3) - RegKeyWord0] = pwdata;
            keys_valid = 0;
          end
          default: ;
        endcase
      end
      if (s_tvalid && s_tready)
        pending_blocks.push_back(cipher_block(s_tuser,
                                              {s_tdata[63:0], s_tdata[127:64]}));
      if (m_tvalid && m_tready) begin
        if (pending_blocks.size() == 0) begin
          $error("result with no block pending: %h", m_tdata);
          errors++;
        end else begin
          want = pending_blocks.pop_front();
          if (m_tdata[63:0] !== want[127:64]) begin
            $error("result_hi expected %h actual %h", want[127:64], m_tdata[63:0]);
            errors++;
          end
          if (m_tdata[127:64] !== want[63:0]) begin
            $error("result_lo expected %h actual %h", want[63:0], m_tdata[127:64]);
            errors++;
          end
        end
      end
    end
    outstanding = pending_blocks.size();
  end
endmodule

### sim/testbench.sv
// Testbench top: drives key setup and blocks into the AES cipher, gives the verdict
`timescale 1ns / 1ps
module testbench;
  import aes_pkg::*;
  import aes_tb_pkg::*;

  localparam int StallLimit = 5000;

  logic clk, rst;
  logic psel, penable, pwrite, pready;
  logic [5:0] paddr;
  logic [63:0] pwdata, prdata;
  logic s_tvalid, s_tready, s_tuser;
  logic [127:0] s_tdata;  // block_lo, block_hi
  logic m_tvalid, m_tready;
  logic [127:0] m_tdata;  // result_lo, result_hi
  int errors, outstanding;
  int send_idle, recv_idle;
  int quiet_cycles;

  aes_block_encrypt_decrypt dut (.*);

  aes_block_checker checker_i (
    .clk, .rst, .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
    .s_tvalid, .s_tready, .s_tdata, .s_tuser, .m_tvalid, .m_tready, .m_tdata,
    .errors, .outstanding
  );

  always begin
    clk = 1; #5;
    clk = 0; #5;
  end

  always @(negedge clk) m_tready = $urandom_range(99) >= recv_idle;

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= StallLimit) begin
      $display("[aes_block_encrypt_decrypt] ERROR");
      $finish;
    end
  end

  task automatic write_reg(int idx, bit [63:0] value);
    psel = 1; pwrite = 1; penable = 0;
    paddr = 6'(idx * 8); pwdata = value;
    @(negedge clk);
    penable = 1;
    @(negedge clk);
    psel = 0; penable = 0; pwrite = 0;
  endtask

  task automatic drain();
    while (outstanding != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic load_key(bit [1:0] len, bit [63:0] k0, k1, k2, k3);
    drain();
    write_reg(RegKeySize, 64'(len));
    write_reg(RegKeyWord0, k0);
    write_reg(RegKeyWord1, k1);
    write_reg(RegKeyWord2, k2);
    write_reg(RegKeyWord3, k3);
  endtask

  task automatic send_block(bit fn, bit [63:0] hi, bit [63:0] lo);
    while ($urandom_range(99) < send_idle) begin
      s_tvalid = 0;
      @(negedge clk);
    end
    s_tvalid = 1; s_tuser = fn; s_tdata = {lo, hi};
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
    s_tvalid = 0;
  endtask

  function automatic bit [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic bit [63:0] pick_word();
    case ($urandom_range(9))
      0: return 64'h0;
      1: return '1;
      default: return rand64();
    endcase
  endfunction

  initial begin
    rst = 1; psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
    s_tvalid = 0; s_tuser = FuncEnc; s_tdata = 0; m_tready = 0;
    send_idle = 0; recv_idle = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // block before any key write uses the all-zero 128-bit key
    send_block(FuncEnc, 64'h0, 64'h0);
    send_block(FuncDec, '1, '1);
    load_key(2'd0, 64'h0001020304050607, 64'h08090a0b0c0d0e0f, '1, '1);
    send_block(FuncEnc, 64'h0011223344556677, 64'h8899aabbccddeeff);
    send_block(FuncDec, 64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a);
    send_block(FuncEnc, '1, '1);
    load_key(2'd1, 64'h0001020304050607, 64'h08090a0b0c0d0e0f, 64'h1011121314151617,
             64'h0);
    send_block(FuncEnc, 64'h0011223344556677, 64'h8899aabbccddeeff);
    send_block(FuncDec, 64'hdda97ca4864cdfe0, 64'h6eaf70a0ec0d7191);
    load_key(2'd2, 64'h0001020304050607, 64'h08090a0b0c0d0e0f,
             64'h1011121314151617, 64'h18191a1b1c1d1e1f);
    send_block(FuncEnc, 64'h0011223344556677, 64'h8899aabbccddeeff);
    send_block(FuncDec, 64'h8ea2b7ca516745bf, 64'heafc49904b496089);
    // key size three behaves as a 256-bit key
    load_key(2'd3, '1, '1, '1, '1);
    send_block(FuncEnc, 64'h0, '1);
    send_block(FuncDec, '1, 64'h0);

    for (int phase = 0; phase < 3; phase++) begin
      send_idle = phase == 0 ? 27 : (phase == 1 ? 75 : 0);
      recv_idle = phase == 0 ? 75 : (phase == 1 ? 27 : 0);
      for (int n = 0; n < 250; n++) begin
        if (n % 40 == 0)
          load_key(2'($urandom_range(3)), pick_word(), pick_word(), pick_word(), pick_word());
        send_block(1'($urandom_range(1)), pick_word(), pick_word());
      end
    end
    s_tvalid = 0;
    drain();

    if (errors == 0)
      $display("[aes_block_encrypt_decrypt] OK");
    else
      $display("[aes_block_encrypt_decrypt] ERROR");
    $finish;
  end
endmodule
